@@ rtl/tscu_pkg.sv @@
// Shared constants, types and the constant sine table for the sine/cosine unit.
`default_nettype none
package tscu_pkg;

    localparam int TableSize = 256;
    localparam int IdxBits   = 8;
    localparam int FracBits  = 16;
    localparam int ExtraBits = 8;
    localparam int WorkBits  = FracBits + ExtraBits;
    localparam int ValBits   = FracBits + 2;

    localparam longint unsigned Pi4Q31      = 64'd1686629713;
    localparam longint unsigned TwoPiQ60    = 64'h6487ED5110B4611B;
    localparam longint unsigned InvTwoPiQ34 = 64'd2734261102;
    localparam longint unsigned OneQ31      = 64'd2147483648;

    // 2*pi/N in Q(WorkBits)
    localparam longint unsigned StepQ =
        ((TwoPiQ60 >> (60 - WorkBits)) + TableSize / 2) / TableSize;

    // Taylor term divisors: (2n)(2n+1) for sine, (2n-1)(2n) for cosine
    localparam longint unsigned SinDiv1 = 64'd6;
    localparam longint unsigned SinDiv2 = 64'd20;
    localparam longint unsigned SinDiv3 = 64'd42;
    localparam longint unsigned SinDiv4 = 64'd72;
    localparam longint unsigned SinDiv5 = 64'd110;
    localparam longint unsigned SinDiv6 = 64'd156;
    localparam longint unsigned CosDiv1 = 64'd2;
    localparam longint unsigned CosDiv2 = 64'd12;
    localparam longint unsigned CosDiv3 = 64'd30;
    localparam longint unsigned CosDiv4 = 64'd56;
    localparam longint unsigned CosDiv5 = 64'd90;
    localparam longint unsigned CosDiv6 = 64'd132;

    localparam logic OP_SIN = 1'b0;
    localparam logic OP_COS = 1'b1;

    typedef logic signed [ValBits-1:0] rom_word_t;
    typedef rom_word_t rom_t [TableSize];

    function automatic longint clamp_q31(longint sum);
        longint r;
        r = sum;
        if (r < 0) r = 0;
        if (r > longint'(OneQ31)) r = longint'(OneQ31);
        return r;
    endfunction

    function automatic longint sine_series_q31(longint unsigned a, longint unsigned a2);
        longint unsigned term;
        longint          sum;
        term = a;
        sum  = longint'(a);
        term = ((term * a2) >> 31) / SinDiv1;
        sum  = sum - longint'(term);
        term = ((term * a2) >> 31) / SinDiv2;
        sum  = sum + longint'(term);
        term = ((term * a2) >> 31) / SinDiv3;
        sum  = sum - longint'(term);
        term = ((term * a2) >> 31) / SinDiv4;
        sum  = sum + longint'(term);
        term = ((term * a2) >> 31) / SinDiv5;
        sum  = sum - longint'(term);
        term = ((term * a2) >> 31) / SinDiv6;
        sum  = sum + longint'(term);
        return clamp_q31(sum);
    endfunction

    function automatic longint cosine_series_q31(longint unsigned a2);
        longint unsigned term;
        longint          sum;
        term = OneQ31;
        sum  = longint'(OneQ31);
        term = ((term * a2) >> 31) / CosDiv1;
        sum  = sum - longint'(term);
        term = ((term * a2) >> 31) / CosDiv2;
        sum  = sum + longint'(term);
        term = ((term * a2) >> 31) / CosDiv3;
        sum  = sum - longint'(term);
        term = ((term * a2) >> 31) / CosDiv4;
        sum  = sum + longint'(term);
        term = ((term * a2) >> 31) / CosDiv5;
        sum  = sum - longint'(term);
        term = ((term * a2) >> 31) / CosDiv6;
        sum  = sum + longint'(term);
        return clamp_q31(sum);
    endfunction

    function automatic rom_word_t rom_entry(int unsigned i);
        longint unsigned m, oct, r, num, a, a2;
        longint          q31, v;
        m   = 8 * (i % TableSize);
        oct = m / TableSize;
        r   = m % TableSize;
        num = oct[0] ? (TableSize - r) : r;
        a   = (Pi4Q31 * num + TableSize / 2) / TableSize;
        a2  = (a * a) >> 31;
        if (oct == 1 || oct == 2 || oct == 5 || oct == 6)
            q31 = cosine_series_q31(a2);
        else
            q31 = sine_series_q31(a, a2);
        v = longint'((longint'(q31) + (64'd1 << (30 - FracBits))) >> (31 - FracBits));
        if (oct >= 4) v = -v;
        return rom_word_t'(v);
    endfunction

    function automatic rom_t build_rom();
        rom_t t;
        for (int i = 0; i < TableSize; i++) t[i] = rom_entry(i);
        return t;
    endfunction

    localparam rom_t SIN_ROM = build_rom();

    // shift right by sh, rounding half away from zero
    function automatic logic signed [63:0] shr_round(logic signed [63:0] v, int sh);
        logic [63:0] mag;
        logic [63:0] q;
        mag = v[63] ? (64'd0 - v) : v;
        q   = (mag + (64'd1 << (sh - 1))) >> sh;
        return v[63] ? -$signed(q) : $signed(q);
    endfunction

endpackage
`default_nettype wire

@@ rtl/tscu_poly.sv @@
// Second-order correction pipeline: table values and residual in, rounded result out.
`default_nettype none
module tscu_poly (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic                                  in_op,
    input  wire tscu_pkg::rom_word_t                   in_s,
    input  wire tscu_pkg::rom_word_t                   in_c,
    input  wire logic signed [tscu_pkg::WorkBits-1:0]  in_d,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output tscu_pkg::rom_word_t                        out_value
);
    localparam int WB = tscu_pkg::WorkBits;
    localparam int VB = tscu_pkg::ValBits;
    localparam int P1B = VB + WB;
    localparam int IB = VB + tscu_pkg::ExtraBits + 2;
    localparam int P2B = IB + WB;

    logic vd_reg, ve_reg, vf_reg, vg_reg;
    logic rd_d, rd_e, rd_f, rd_g;

    assign rd_g = !vg_reg || out_ready;
    assign rd_f = !vf_reg || rd_g;
    assign rd_e = !ve_reg || rd_f;
    assign rd_d = !vd_reg || rd_e;
    assign in_ready = rd_d;

    // stage D
    logic                  d_op_reg;
    tscu_pkg::rom_word_t   d_a_reg, d_b_reg;
    logic signed [WB-1:0]  d_d_reg;
    logic signed [P1B-1:0] d_p1_reg;
    tscu_pkg::rom_word_t   sel_a, sel_b;
    assign sel_a = (in_op == tscu_pkg::OP_COS) ? in_c : in_s;
    assign sel_b = (in_op == tscu_pkg::OP_COS) ? in_s : in_c;

    // stage E
    logic                  e_op_reg;
    tscu_pkg::rom_word_t   e_a_reg;
    logic signed [WB-1:0]  e_d_reg;
    logic signed [IB-1:0]  e_inner_reg;
    logic signed [63:0]    r1;
    logic signed [IB-1:0]  inner_next;
    assign r1 = tscu_pkg::shr_round(64'(d_p1_reg), tscu_pkg::FracBits + 1);
    assign inner_next = (IB'(d_b_reg) <<< tscu_pkg::ExtraBits)
                      + ((d_op_reg == tscu_pkg::OP_COS) ? IB'(r1) : -IB'(r1));

    // stage F
    logic                  f_op_reg;
    tscu_pkg::rom_word_t   f_a_reg;
    logic signed [P2B-1:0] f_p2_reg;

    // stage G
    logic signed [63:0] r2, sum, rr;
    tscu_pkg::rom_word_t value_next;
    tscu_pkg::rom_word_t value_reg;
    assign r2  = tscu_pkg::shr_round(64'(f_p2_reg), WB);
    assign sum = (64'(f_a_reg) <<< tscu_pkg::ExtraBits)
               + ((f_op_reg == tscu_pkg::OP_COS) ? -r2 : r2);
    assign rr  = tscu_pkg::shr_round(sum, tscu_pkg::ExtraBits);

    always_comb begin
        if (rr > 64'sd0 + ((64'sd1 <<< (VB - 1)) - 64'sd1))
            value_next = {1'b0, {(VB-1){1'b1}}};
        else if (rr < -(64'sd1 <<< (VB - 1)))
            value_next = {1'b1, {(VB-1){1'b0}}};
        else
            value_next = rr[VB-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
            vg_reg <= 1'b0;
        end else begin
            if (rd_d) vd_reg <= in_valid;
            if (rd_e) ve_reg <= vd_reg;
            if (rd_f) vf_reg <= ve_reg;
            if (rd_g) vg_reg <= vf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_d) begin
            d_op_reg <= in_op;
            d_a_reg  <= sel_a;
            d_b_reg  <= sel_b;
            d_d_reg  <= in_d;
            d_p1_reg <= P1B'(sel_a) * P1B'(in_d);
        end
        if (rd_e) begin
            e_op_reg    <= d_op_reg;
            e_a_reg     <= d_a_reg;
            e_d_reg     <= d_d_reg;
            e_inner_reg <= inner_next;
        end
        if (rd_f) begin
            f_op_reg <= e_op_reg;
            f_a_reg  <= e_a_reg;
            f_p2_reg <= P2B'(e_inner_reg) * P2B'(e_d_reg);
        end
        if (rd_g) value_reg <= value_next;
    end

    assign out_valid = vg_reg;
    assign out_value = value_reg;
endmodule
`default_nettype wire

@@ rtl/table_sine_cosine_unit.sv @@
// Top level of the table-driven sine/cosine unit.
// Takes one angle (radians, Q15.16) per clock and returns sin or cos in Q1.16,
// rounded and saturated. Stages in order: magnitude times 1/(2*pi),
// index and k*step product, residual and table read, then four stages of
// correction (s*d, inner sum, inner*d, final round and clamp). Every stage
// holds its item under backpressure, so throughput is one item per cycle
// whenever the result side keeps up. The sine table is a constant 256-entry
// ROM read at two addresses per item.
`default_nettype none
module table_sine_cosine_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] angle
    input  wire logic [0:0]  s_tuser,   // [0] opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // [17:0] value
);
    localparam int WB = tscu_pkg::WorkBits;
    localparam int KB = 23;
    localparam int KHB = 44;

    logic va_reg, vb_reg, vc_reg;
    logic rd_a, rd_b, rd_c, poly_ready;
    assign rd_c = !vc_reg || poly_ready;
    assign rd_b = !vb_reg || rd_c;
    assign rd_a = !va_reg || rd_b;
    assign s_tready = rd_a;

    // stage A
    logic signed [31:0] x_in;
    logic [31:0] mag;
    logic        a_op_reg, a_neg_reg;
    logic signed [31:0] a_x_reg;
    logic [63:0] a_prod_reg;
    assign x_in = s_tdata;
    assign mag  = x_in[31] ? (32'd0 - s_tdata) : s_tdata;

    // stage B
    logic [45:0] tk;
    logic [21:0] kmag;
    logic signed [KB-1:0] k;
    logic        b_op_reg, b_neg_reg;
    logic signed [31:0] b_x_reg;
    logic [tscu_pkg::IdxBits-1:0] b_km_reg;
    logic signed [KHB-1:0] b_kh_reg;
    assign tk   = a_prod_reg[63:18] + 46'd8388608;
    assign kmag = tk[45:24];
    assign k    = a_neg_reg ? -$signed({1'b0, kmag}) : $signed({1'b0, kmag});

    // stage C
    logic signed [KHB-1:0] dfull;
    logic [tscu_pkg::IdxBits-1:0] si, ci;
    logic        c_op_reg;
    tscu_pkg::rom_word_t c_s_reg, c_c_reg;
    logic signed [WB-1:0] c_d_reg;
    assign dfull = (KHB'(b_x_reg) <<< tscu_pkg::ExtraBits) - b_kh_reg;
    assign si = b_neg_reg ? (tscu_pkg::IdxBits'(0) - b_km_reg) : b_km_reg;
    assign ci = si + tscu_pkg::IdxBits'(tscu_pkg::TableSize / 4);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else begin
            if (rd_a) va_reg <= s_tvalid;
            if (rd_b) vb_reg <= va_reg;
            if (rd_c) vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_a) begin
            a_op_reg   <= s_tuser[0];
            a_neg_reg  <= x_in[31];
            a_x_reg    <= x_in;
            a_prod_reg <= 64'(mag) * 64'(tscu_pkg::InvTwoPiQ34[31:0]);
        end
        if (rd_b) begin
            b_op_reg  <= a_op_reg;
            b_neg_reg <= a_neg_reg;
            b_x_reg   <= a_x_reg;
            b_km_reg  <= kmag[tscu_pkg::IdxBits-1:0];
            b_kh_reg  <= KHB'(k) * $signed({1'b0, tscu_pkg::StepQ[20:0]});
        end
        if (rd_c) begin
            c_op_reg <= b_op_reg;
            c_d_reg  <= dfull[WB-1:0];
            c_s_reg  <= tscu_pkg::SIN_ROM[si];
            c_c_reg  <= tscu_pkg::SIN_ROM[ci];
        end
    end

    tscu_pkg::rom_word_t value;

    tscu_poly u_poly (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (vc_reg),
        .in_ready  (poly_ready),
        .in_op     (c_op_reg),
        .in_s      (c_s_reg),
        .in_c      (c_c_reg),
        .in_d      (c_d_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_value (value)
    );

    assign m_tdata = {6'd0, value};
endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Testbench for table_sine_cosine_unit: predicts each sine or cosine value and checks it.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    table_sine_cosine_unit DUT (.*);

    always #10 aclk = ~aclk;

    localparam int Latency = 7;

    logic signed [tscu_pkg::ValBits-1:0] expected_values [$];
    int error_count = 0;
    bit hold_off = 1'b0;
    bit stall_enable = 1'b1;
    int gap_max = 4;
    logic signed [tscu_pkg::ValBits-1:0] sine_table [tscu_pkg::TableSize];

    // Local table build from the Q31 Taylor series
    function automatic longint series_q31(longint unsigned first, longint unsigned a2,
                                          int unsigned k0);
        longint unsigned term;
        longint sum;
        int unsigned k;
        term = first;
        sum = longint'(first);
        k = k0;
        for (int n = 0; n < 6; n++) begin
            term = ((term * a2) >> 31) / (longint'(k) * longint'(k + 1));
            if (n % 2 == 1) sum += longint'(term);
            else sum -= longint'(term);
            k += 2;
        end
        if (sum < 0) sum = 0;
        if (sum > longint'(tscu_pkg::OneQ31)) sum = longint'(tscu_pkg::OneQ31);
        return sum;
    endfunction

    function automatic logic signed [tscu_pkg::ValBits-1:0] table_value(int unsigned i);
        longint unsigned m, oct, r, num, a, a2;
        longint q, v;
        m = 8 * (i % tscu_pkg::TableSize);
        oct = m / tscu_pkg::TableSize;
        r = m % tscu_pkg::TableSize;
        num = oct[0] ? (tscu_pkg::TableSize - r) : r;
        a = (tscu_pkg::Pi4Q31 * num + tscu_pkg::TableSize / 2) / tscu_pkg::TableSize;
        a2 = (a * a) >> 31;
        if (oct == 1 || oct == 2 || oct == 5 || oct == 6)
            q = series_q31(tscu_pkg::OneQ31, a2, 1);
        else q = series_q31(a, a2, 2);
        v = (q + (longint'(1) << (30 - tscu_pkg::FracBits))) >>> (31 - tscu_pkg::FracBits);
        if (oct >= 4) v = -v;
        return v[tscu_pkg::ValBits-1:0];
    endfunction

    function automatic longint round_shift(longint v, int sh);
        longint unsigned mag, q;
        mag = (v < 0) ? longint'(-v) : v;
        q = (mag + (64'd1 << (sh - 1))) >> sh;
        return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [tscu_pkg::ValBits-1:0] trig_value(logic op,
                                                              logic signed [31:0] angle);
        longint x, k, step, d, s, c, inner, res, lim;
        longint unsigned mag, turns, kmag, km, si, ci;
        x = angle;
        mag = (x < 0) ? -x : x;
        turns = (mag * tscu_pkg::InvTwoPiQ34) >> (tscu_pkg::FracBits + 2);
        kmag = (turns * tscu_pkg::TableSize + 64'h8000_0000) >> 32;
        k = (x < 0) ? -longint'(kmag) : longint'(kmag);
        step = ((tscu_pkg::TwoPiQ60 >> (60 - tscu_pkg::WorkBits)) + tscu_pkg::TableSize / 2)
             / tscu_pkg::TableSize;
        d = x * (1 << tscu_pkg::ExtraBits) - k * step;
        km = kmag % tscu_pkg::TableSize;
        si = (x < 0) ? (tscu_pkg::TableSize - km) % tscu_pkg::TableSize : km;
        ci = (si + tscu_pkg::TableSize / 4) % tscu_pkg::TableSize;
        s = sine_table[si];
        c = sine_table[ci];
        lim = longint'(1) << (tscu_pkg::FracBits + 1);
        if (op == tscu_pkg::OP_SIN) begin
            inner = c * (1 << tscu_pkg::ExtraBits)
                  - round_shift(s * d, tscu_pkg::FracBits + 1);
            res = s * (1 << tscu_pkg::ExtraBits) + round_shift(inner * d, tscu_pkg::WorkBits);
        end else begin
            inner = s * (1 << tscu_pkg::ExtraBits)
                  + round_shift(c * d, tscu_pkg::FracBits + 1);
            res = c * (1 << tscu_pkg::ExtraBits) - round_shift(inner * d, tscu_pkg::WorkBits);
        end
        res = round_shift(res, tscu_pkg::ExtraBits);
        if (res > lim - 1) res = lim - 1;
        if (res < -lim) res = -lim;
        return res[tscu_pkg::ValBits-1:0];
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    task automatic send_angle(logic op, logic [31:0] angle);
        s_tvalid <= 1'b1;
        s_tdata <= angle;
        s_tuser <= op;
        expected_values.push_back(trig_value(op, angle));
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic idle_gap();
        int n;
        n = $urandom_range(0, gap_max);
        if (n != 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_values.size() != 0) @(negedge aclk);
        repeat (Latency + 2) @(negedge aclk);
    endtask

    function automatic logic [31:0] random_angle();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 32'h0006_4880) ^ {32{$urandom_range(0, 1) == 1}};
            2: return $signed($urandom_range(0, 32'h0001_0000)) - 32'sh0000_8000;
            default: return 32'($urandom_range(0, 600) * 32'd1608) + $urandom_range(0, 3);
        endcase
    endfunction

    // receiver stall pattern and long hold-off
    always @(negedge aclk) begin
        if (hold_off) m_tready <= 1'b0;
        else if (!stall_enable) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge aclk) begin
        logic signed [tscu_pkg::ValBits-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_values.size() == 0) begin
                report_mismatch("result with none expected");
            end else begin
                want = expected_values.pop_front();
                if (m_tdata[tscu_pkg::ValBits-1:0] !== want)
                    report_mismatch($sformatf("value got %0d want %0d",
                        $signed(m_tdata[tscu_pkg::ValBits-1:0]), want));
                if (m_tdata[23:tscu_pkg::ValBits] !== '0)
                    report_mismatch("padding bits not zero");
            end
        end
    end

    task automatic test_directed();
        logic [31:0] angles [] = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
            32'h1, 32'h0001_921F, 32'hFFFE_6DE1, 32'h0003_243F, 32'h0006_487F,
            32'hFFF9_B781, 32'h0000_0648, 32'h0000_0324, 32'hFFFF_FCDC};
        foreach (angles[i]) begin
            send_angle(tscu_pkg::OP_SIN, angles[i]);
            send_angle(tscu_pkg::OP_COS, angles[i]);
        end
        drain();
    endtask

    task automatic test_random_bursts(int count);
        int burst;
        while (count > 0) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
                send_angle(1'($urandom_range(0, 1)), random_angle());
                count--;
            end
            idle_gap();
        end
        drain();
    endtask

    task automatic test_back_to_back(int count);
        stall_enable = 1'b0;
        repeat (count) send_angle(1'($urandom_range(0, 1)), random_angle());
        drain();
        stall_enable = 1'b1;
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (60) @(negedge aclk);
                hold_off = 1'b0;
            end
            repeat (40) send_angle(1'($urandom_range(0, 1)), random_angle());
        join
        drain();
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_random_bursts(550);
        test_back_to_back(100);
        test_backpressure();
        gap_max = 1;
        test_random_bursts(80);
        if (error_count == 0 && expected_values.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        foreach (sine_table[i]) sine_table[i] = table_value(i);
    end

    initial begin
        #2ms;
        $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
rtl/tscu_pkg.sv
rtl/tscu_poly.sv
rtl/table_sine_cosine_unit.sv
tb/testbench.sv
